FILE: src/lbfv_pkg.sv
// shared types and codes for the four-vector lorentz boost pipeline
`timescale 1ns / 1ps
`default_nettype none

package lbfv_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_REST     = 2'd1,
        ST_BAD_MASS = 2'd2,
        ST_SAT      = 2'd3
    } t_status;

    // operation code: inverse boost into the frame's rest frame
    localparam logic OP_INVERSE = 1'b1;

endpackage

`default_nettype wire

FILE: src/lbfv_sqrt.sv
// pipelined integer square root, one root bit per stage, with payload
`timescale 1ns / 1ps
`default_nettype none

module lbfv_sqrt #(
    parameter int ROOT_W = 32,
    parameter int PAY_W  = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [2*ROOT_W-1:0]   i_rad,
    input  wire logic [PAY_W-1:0]      i_pay,
    output logic                       o_valid,
    output logic [ROOT_W-1:0]          o_root,
    output logic [PAY_W-1:0]           o_pay
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;

    logic                r_val  [ROOT_W];
    logic [RAD_W-1:0]    r_rad  [ROOT_W];
    logic [REM_W-1:0]    r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [PAY_W-1:0]    r_pay  [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic                s_val;
        logic [RAD_W-1:0]    s_rad;
        logic [REM_W-1:0]    s_rem;
        logic [ROOT_W-1:0]   s_root;
        logic [PAY_W-1:0]    s_pay;
        logic [REM_W+1:0]    s_cur;
        logic [REM_W+1:0]    s_trial;
        logic [RAD_W-1:0]    n_rad;
        logic [REM_W-1:0]    n_rem;
        logic [ROOT_W-1:0]   n_root;

        // stage input: port for the first stage, previous stage otherwise
        if (s == 0) begin : g_first
            assign s_val  = i_valid;
            assign s_rad  = i_rad;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_pay  = i_pay;
        end else begin : g_next
            assign s_val  = r_val[s-1];
            assign s_rad  = r_rad[s-1];
            assign s_rem  = r_rem[s-1];
            assign s_root = r_root[s-1];
            assign s_pay  = r_pay[s-1];
        end

        // bring down two radicand bits and try the next root bit
        assign s_cur   = {s_rem, s_rad[RAD_W-1 -: 2]};
        assign s_trial = {1'b0, s_root, 2'b01};
        assign n_rad   = {s_rad[RAD_W-3:0], 2'b00};

        always_comb begin
            if (s_cur >= s_trial) begin
                n_rem  = REM_W'(s_cur - s_trial);
                n_root = {s_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = s_cur[REM_W-1:0];
                n_root = {s_root[ROOT_W-2:0], 1'b0};
            end
        end

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[s] <= 1'b0;
            end else begin
                r_val[s] <= s_val;
            end
        end

        // stage data
        always_ff @(posedge i_clk) begin
            r_rad[s]  <= n_rad;
            r_rem[s]  <= n_rem;
            r_root[s] <= n_root;
            r_pay[s]  <= s_pay;
        end
    end

    assign o_valid = r_val[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_pay   = r_pay[ROOT_W-1];

endmodule

`default_nettype wire

FILE: src/lbfv_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage, with payload
`timescale 1ns / 1ps
`default_nettype none

module lbfv_div #(
    parameter int NUM_W = 65,
    parameter int DEN_W = 32,
    parameter int PAY_W = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [NUM_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]   i_den,
    input  wire logic [PAY_W-1:0]   i_pay,
    output logic                    o_valid,
    output logic [NUM_W-1:0]        o_quo,
    output logic [PAY_W-1:0]        o_pay
);

    logic                r_val [NUM_W];
    logic [NUM_W-1:0]    r_num [NUM_W];
    logic [NUM_W-1:0]    r_quo [NUM_W];
    logic [DEN_W-1:0]    r_rem [NUM_W];
    logic [DEN_W-1:0]    r_den [NUM_W];
    logic [PAY_W-1:0]    r_pay [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic                s_val;
        logic [NUM_W-1:0]    s_num;
        logic [NUM_W-1:0]    s_quo;
        logic [DEN_W-1:0]    s_rem;
        logic [DEN_W-1:0]    s_den;
        logic [PAY_W-1:0]    s_pay;
        logic [DEN_W:0]      s_cur;
        logic                s_bit;
        logic [DEN_W-1:0]    n_rem;

        // stage input
        if (s == 0) begin : g_first
            assign s_val = i_valid;
            assign s_num = i_num;
            assign s_quo = '0;
            assign s_rem = '0;
            assign s_den = i_den;
            assign s_pay = i_pay;
        end else begin : g_next
            assign s_val = r_val[s-1];
            assign s_num = r_num[s-1];
            assign s_quo = r_quo[s-1];
            assign s_rem = r_rem[s-1];
            assign s_den = r_den[s-1];
            assign s_pay = r_pay[s-1];
        end

        // shift in next dividend bit, subtract when it fits
        assign s_cur = {s_rem, s_num[NUM_W-1]};
        assign s_bit = (s_cur >= {1'b0, s_den});
        assign n_rem = s_bit ? DEN_W'(s_cur - {1'b0, s_den}) : s_cur[DEN_W-1:0];

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[s] <= 1'b0;
            end else begin
                r_val[s] <= s_val;
            end
        end

        // stage data
        always_ff @(posedge i_clk) begin
            r_num[s] <= {s_num[NUM_W-2:0], 1'b0};
            r_quo[s] <= {s_quo[NUM_W-2:0], s_bit};
            r_rem[s] <= n_rem;
            r_den[s] <= s_den;
            r_pay[s] <= s_pay;
        end
    end

    assign o_valid = r_val[NUM_W-1];
    assign o_quo   = r_quo[NUM_W-1];
    assign o_pay   = r_pay[NUM_W-1];

endmodule

`default_nettype wire

FILE: src/lorentz_boost_four_vector.sv
// top level: fully pipelined lorentz boost of a four-momentum
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input: drive the vector, the frame four-momentum and i_operation with
//   start high; the beat is taken at a rising edge where start is high and
//   busy is low. busy is low whenever reset is inactive, so one beat can
//   enter every cycle.
//   Output: o_valid is high for exactly one cycle with o_out_* and o_status;
//   results leave in the order the beats came in. The receiver cannot stall.
//   Throughput: one item per cycle. The pipeline holds the one-bit-per-stage
//   square root (WORD_WIDTH stages), the frame mass divider (2*WORD_WIDTH+1
//   stages) and the three momentum dividers (3*WORD_WIDTH+1 stages each).
//   Status: frame at rest passes the vector through (checked first), a
//   nonpositive frame mass passes it through, overflow clamps to the rails.
//   Reset: synchronous, active low; clears every stage valid bit, so items
//   in flight are dropped and no result is given for them.
module lorentz_boost_four_vector #(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   i_operation,
    input  wire logic [WORD_WIDTH-1:0]  i_vec_px,
    input  wire logic [WORD_WIDTH-1:0]  i_vec_py,
    input  wire logic [WORD_WIDTH-1:0]  i_vec_pz,
    input  wire logic [WORD_WIDTH-1:0]  i_vec_energy,
    input  wire logic [WORD_WIDTH-1:0]  i_frame_px,
    input  wire logic [WORD_WIDTH-1:0]  i_frame_py,
    input  wire logic [WORD_WIDTH-1:0]  i_frame_pz,
    input  wire logic [WORD_WIDTH-1:0]  i_frame_energy,
    output logic                        o_valid,
    output logic [WORD_WIDTH-1:0]       o_out_px,
    output logic [WORD_WIDTH-1:0]       o_out_py,
    output logic [WORD_WIDTH-1:0]       o_out_pz,
    output logic [WORD_WIDTH-1:0]       o_out_energy,
    output lbfv_pkg::t_status           o_status
);

    import lbfv_pkg::*;

    localparam int W       = WORD_WIDTH;
    localparam int DOT_W   = 2 * W + 2;   // signed dot product and pf4
    localparam int DQ_W    = 2 * W + 1;   // magnitudes of dot, pf4, num
    localparam int DEN_W   = W + 1;       // signed eq + m and its magnitude
    localparam int PROD_W  = 3 * W + 1;   // magnitude of num * q
    localparam int T_W     = PROD_W + 1;  // signed momentum increment
    localparam int SUM_W   = T_W + 1;     // momentum plus increment
    localparam int LATENCY = 6 * W + 13;

    typedef struct packed {
        logic                  op;
        logic                  rest;
        logic                  bad;
        logic [DOT_W-1:0]      dot;
        logic [3:0][W-1:0]     p;
        logic [3:0][W-1:0]     q;
    } t_sq_pay;

    typedef struct packed {
        logic                  op;
        logic                  rest;
        logic                  bad;
        logic                  dneg;
        logic                  denneg;
        logic [3:0][W-1:0]     p;
        logic [2:0][W-1:0]     q;
    } t_d1_pay;

    typedef struct packed {
        logic                  sgn;
        logic [W-1:0]          p;
        logic                  rest;
        logic                  bad;
        logic [DOT_W-1:0]      pf4;
        logic [W-1:0]          e;
    } t_lead_pay;

    typedef struct packed {
        logic                  sgn;
        logic [W-1:0]          p;
    } t_lane_pay;

    // clamp a wide signed value to the word, msb of result flags overflow
    function automatic logic [W:0] sat_word(input logic [SUM_W-1:0] v);
        logic fits;
        fits = (v[SUM_W-1:W-1] == '0) || (v[SUM_W-1:W-1] == '1);
        if (fits) begin
            sat_word = {1'b0, v[W-1:0]};
        end else if (v[SUM_W-1]) begin
            sat_word = {1'b1, 1'b1, {(W-1){1'b0}}};
        end else begin
            sat_word = {1'b1, 1'b0, {(W-1){1'b1}}};
        end
    endfunction

    // accept
    logic accept;
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // stage 1: input register
    logic                r1_val;
    logic                r1_op;
    logic [3:0][W-1:0]   r1_p;
    logic [3:0][W-1:0]   r1_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_val <= 1'b0;
        end else begin
            r1_val <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_op <= i_operation;
        r1_p  <= {i_vec_energy, i_vec_pz, i_vec_py, i_vec_px};
        r1_q  <= {i_frame_energy, i_frame_pz, i_frame_py, i_frame_px};
    end

    // stage 2: products and frame at rest check
    logic                  r2_val;
    logic                  r2_op;
    logic                  r2_rest;
    logic [3:0][W-1:0]     r2_p;
    logic [3:0][W-1:0]     r2_q;
    logic [3:0][2*W-1:0]   r2_pq;
    logic [3:0][2*W-1:0]   r2_qq;
    logic [3:0][2*W-1:0]   n2_pq;
    logic [3:0][2*W-1:0]   n2_qq;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n2_pq[i] = $signed(r1_p[i]) * $signed(r1_q[i]);
            n2_qq[i] = $signed(r1_q[i]) * $signed(r1_q[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_val <= 1'b0;
        end else begin
            r2_val <= r1_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_op   <= r1_op;
        r2_rest <= (r1_q[0] == '0) && (r1_q[1] == '0) && (r1_q[2] == '0);
        r2_p    <= r1_p;
        r2_q    <= r1_q;
        r2_pq   <= n2_pq;
        r2_qq   <= n2_qq;
    end

    // stage 3: dot product and squared norms
    logic                      r3_val;
    logic                      r3_op;
    logic                      r3_rest;
    logic [3:0][W-1:0]         r3_p;
    logic [3:0][W-1:0]         r3_q;
    logic signed [DOT_W-1:0]   r3_dot;
    logic [2*W-1:0]            r3_q2;
    logic [2*W-1:0]            r3_e2;
    logic signed [DOT_W-1:0]   n3_dot;

    always_comb begin
        n3_dot = DOT_W'($signed(r2_pq[3]));
        for (int i = 0; i < 3; i++) begin
            if (r2_op == OP_INVERSE) begin
                n3_dot = n3_dot - DOT_W'($signed(r2_pq[i]));
            end else begin
                n3_dot = n3_dot + DOT_W'($signed(r2_pq[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_val <= 1'b0;
        end else begin
            r3_val <= r2_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_op   <= r2_op;
        r3_rest <= r2_rest;
        r3_p    <= r2_p;
        r3_q    <= r2_q;
        r3_dot  <= n3_dot;
        r3_q2   <= r2_qq[0] + r2_qq[1] + r2_qq[2];
        r3_e2   <= r2_qq[3];
    end

    // stage 4: mass squared and its sign
    logic             r4_val;
    logic [2*W-1:0]   r4_rad;
    t_sq_pay          r4_pay;
    logic             n4_bad;

    assign n4_bad = (r3_e2 <= r3_q2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_val <= 1'b0;
        end else begin
            r4_val <= r3_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_rad <= n4_bad ? '0 : r3_e2 - r3_q2;
        r4_pay <= '{op: r3_op, rest: r3_rest, bad: n4_bad, dot: r3_dot,
                    p: r3_p, q: r3_q};
    end

    // frame mass
    logic          sq_val;
    logic [W-1:0]  sq_root;
    t_sq_pay       sq_pay;

    lbfv_sqrt #(
        .ROOT_W (W),
        .PAY_W  ($bits(t_sq_pay))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_val),
        .i_rad   (r4_rad),
        .i_pay   (r4_pay),
        .o_valid (sq_val),
        .o_root  (sq_root),
        .o_pay   (sq_pay)
    );

    // stage 5: dot magnitude, boost denominator eq + m
    logic                     r5_val;
    logic [DQ_W-1:0]          r5_dmag;
    logic [W-1:0]             r5_m;
    logic [DEN_W-1:0]         r5_denmag;
    t_d1_pay                  r5_pay;
    logic signed [DEN_W-1:0]  n5_den;
    logic                     n5_dneg;

    assign n5_den  = DEN_W'($signed(sq_pay.q[3])) + $signed({1'b0, sq_root});
    assign n5_dneg = sq_pay.dot[DOT_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_val <= 1'b0;
        end else begin
            r5_val <= sq_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_dmag   <= n5_dneg ? DQ_W'(-sq_pay.dot) : DQ_W'(sq_pay.dot);
        r5_m      <= sq_root;
        r5_denmag <= n5_den[DEN_W-1] ? DEN_W'(-n5_den) : DEN_W'(n5_den);
        r5_pay    <= '{op: sq_pay.op, rest: sq_pay.rest, bad: sq_pay.bad,
                       dneg: n5_dneg, denneg: n5_den[DEN_W-1], p: sq_pay.p,
                       q: sq_pay.q[2:0]};
    end

    // pf4 magnitude = |dot| / m
    logic              d1_val;
    logic [DQ_W-1:0]   d1_quo;
    logic [DEN_W-1:0]  d1_denmag;
    t_d1_pay           d1_pay;

    lbfv_div #(
        .NUM_W (DQ_W),
        .DEN_W (W),
        .PAY_W ($bits(t_d1_pay) + DEN_W)
    ) u_div_mass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_val),
        .i_num   (r5_dmag),
        .i_den   (r5_m),
        .i_pay   ({r5_pay, r5_denmag}),
        .o_valid (d1_val),
        .o_quo   (d1_quo),
        .o_pay   ({d1_pay, d1_denmag})
    );

    // stage 6: signed pf4 and num = pf4 + e
    logic                     r6_val;
    logic signed [DOT_W-1:0]  r6_pf4;
    logic signed [DOT_W-1:0]  r6_num;
    logic [DEN_W-1:0]         r6_denmag;
    t_d1_pay                  r6_pay;
    logic signed [DOT_W-1:0]  n6_pf4;

    assign n6_pf4 = d1_pay.dneg ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_val <= 1'b0;
        end else begin
            r6_val <= d1_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_pf4    <= n6_pf4;
        r6_num    <= n6_pf4 + DOT_W'($signed(d1_pay.p[3]));
        r6_denmag <= d1_denmag;
        r6_pay    <= d1_pay;
    end

    // stage 7: magnitudes and per-lane result signs
    logic                     r7_val;
    logic [DQ_W-1:0]          r7_nmag;
    logic [2:0][W-1:0]        r7_qmag;
    logic [2:0]               r7_sgn;
    logic signed [DOT_W-1:0]  r7_pf4;
    logic [DEN_W-1:0]         r7_denmag;
    logic                     r7_rest;
    logic                     r7_bad;
    logic [3:0][W-1:0]        r7_p;
    logic [2:0][W-1:0]        n7_qmag;
    logic [2:0]               n7_sgn;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n7_qmag[i] = r6_pay.q[i][W-1] ? W'(0 - r6_pay.q[i]) : r6_pay.q[i];
            n7_sgn[i]  = (r6_pay.op == OP_INVERSE) ^ r6_num[DOT_W-1]
                       ^ r6_pay.q[i][W-1] ^ r6_pay.denneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_val <= 1'b0;
        end else begin
            r7_val <= r6_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_nmag   <= r6_num[DOT_W-1] ? DQ_W'(-r6_num) : DQ_W'(r6_num);
        r7_qmag   <= n7_qmag;
        r7_sgn    <= n7_sgn;
        r7_pf4    <= r6_pf4;
        r7_denmag <= r6_denmag;
        r7_rest   <= r6_pay.rest;
        r7_bad    <= r6_pay.bad;
        r7_p      <= r6_pay.p;
    end

    // stage 8: partial products of |num| * |q|
    logic                     r8_val;
    logic [2:0][2*W-1:0]      r8_lo;
    logic [2:0][2*W:0]        r8_hi;
    logic [2:0]               r8_sgn;
    logic signed [DOT_W-1:0]  r8_pf4;
    logic [DEN_W-1:0]         r8_denmag;
    logic                     r8_rest;
    logic                     r8_bad;
    logic [3:0][W-1:0]        r8_p;
    logic [2:0][2*W-1:0]      n8_lo;
    logic [2:0][2*W:0]        n8_hi;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n8_lo[i] = (2*W)'(r7_nmag[W-1:0]) * (2*W)'(r7_qmag[i]);
            n8_hi[i] = (2*W+1)'(r7_nmag[DQ_W-1:W]) * (2*W+1)'(r7_qmag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_val <= 1'b0;
        end else begin
            r8_val <= r7_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_lo     <= n8_lo;
        r8_hi     <= n8_hi;
        r8_sgn    <= r7_sgn;
        r8_pf4    <= r7_pf4;
        r8_denmag <= r7_denmag;
        r8_rest   <= r7_rest;
        r8_bad    <= r7_bad;
        r8_p      <= r7_p;
    end

    // stage 9: combine partial products
    logic                     r9_val;
    logic [2:0][PROD_W-1:0]   r9_prod;
    logic [2:0]               r9_sgn;
    logic signed [DOT_W-1:0]  r9_pf4;
    logic [DEN_W-1:0]         r9_denmag;
    logic                     r9_rest;
    logic                     r9_bad;
    logic [3:0][W-1:0]        r9_p;
    logic [2:0][PROD_W-1:0]   n9_prod;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n9_prod[i] = {r8_hi[i], {W{1'b0}}} + PROD_W'(r8_lo[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_val <= 1'b0;
        end else begin
            r9_val <= r8_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r9_prod   <= n9_prod;
        r9_sgn    <= r8_sgn;
        r9_pf4    <= r8_pf4;
        r9_denmag <= r8_denmag;
        r9_rest   <= r8_rest;
        r9_bad    <= r8_bad;
        r9_p      <= r8_p;
    end

    // momentum increments: |num * q| / |eq + m|, one divider per lane
    logic [2:0]               d2_val;
    logic [2:0][PROD_W-1:0]   d2_quo;
    t_lead_pay                d2_lead;
    t_lane_pay                d2_lane1;
    t_lane_pay                d2_lane2;
    t_lead_pay                lead_in;
    t_lane_pay                lane1_in;
    t_lane_pay                lane2_in;

    assign lead_in  = '{sgn: r9_sgn[0], p: r9_p[0], rest: r9_rest, bad: r9_bad,
                        pf4: r9_pf4, e: r9_p[3]};
    assign lane1_in = '{sgn: r9_sgn[1], p: r9_p[1]};
    assign lane2_in = '{sgn: r9_sgn[2], p: r9_p[2]};

    lbfv_div #(
        .NUM_W (PROD_W),
        .DEN_W (DEN_W),
        .PAY_W ($bits(t_lead_pay))
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r9_val),
        .i_num   (r9_prod[0]),
        .i_den   (r9_denmag),
        .i_pay   (lead_in),
        .o_valid (d2_val[0]),
        .o_quo   (d2_quo[0]),
        .o_pay   (d2_lead)
    );

    lbfv_div #(
        .NUM_W (PROD_W),
        .DEN_W (DEN_W),
        .PAY_W ($bits(t_lane_pay))
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r9_val),
        .i_num   (r9_prod[1]),
        .i_den   (r9_denmag),
        .i_pay   (lane1_in),
        .o_valid (d2_val[1]),
        .o_quo   (d2_quo[1]),
        .o_pay   (d2_lane1)
    );

    lbfv_div #(
        .NUM_W (PROD_W),
        .DEN_W (DEN_W),
        .PAY_W ($bits(t_lane_pay))
    ) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r9_val),
        .i_num   (r9_prod[2]),
        .i_den   (r9_denmag),
        .i_pay   (lane2_in),
        .o_valid (d2_val[2]),
        .o_quo   (d2_quo[2]),
        .o_pay   (d2_lane2)
    );

    // stage 10: signed increments
    logic                  r10_val;
    logic [2:0][T_W-1:0]   r10_t;
    logic [3:0][W-1:0]     r10_p;
    logic [DOT_W-1:0]      r10_pf4;
    logic                  r10_rest;
    logic                  r10_bad;
    logic [2:0]            n10_sgn;
    logic [2:0][T_W-1:0]   n10_t;

    assign n10_sgn = {d2_lane2.sgn, d2_lane1.sgn, d2_lead.sgn};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n10_t[i] = n10_sgn[i] ? T_W'(-$signed({1'b0, d2_quo[i]}))
                                  : T_W'($signed({1'b0, d2_quo[i]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_val <= 1'b0;
        end else begin
            r10_val <= &d2_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r10_t    <= n10_t;
        r10_p    <= {d2_lead.e, d2_lane2.p, d2_lane1.p, d2_lead.p};
        r10_pf4  <= d2_lead.pf4;
        r10_rest <= d2_lead.rest;
        r10_bad  <= d2_lead.bad;
    end

    // stage 11: add, saturate, pick status
    logic [3:0][W:0]   n11_sat;
    logic [3:0][W-1:0] n11_out;
    t_status           n11_status;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n11_sat[i] = sat_word(SUM_W'($signed(r10_p[i])) + SUM_W'($signed(r10_t[i])));
        end
        n11_sat[3] = sat_word(SUM_W'($signed(r10_pf4)));
        priority if (r10_rest) begin
            n11_status = ST_REST;
            n11_out    = r10_p;
        end else if (r10_bad) begin
            n11_status = ST_BAD_MASS;
            n11_out    = r10_p;
        end else begin
            n11_status = (n11_sat[0][W] | n11_sat[1][W] | n11_sat[2][W] | n11_sat[3][W])
                       ? ST_SAT : ST_DONE;
            for (int i = 0; i < 4; i++) begin
                n11_out[i] = n11_sat[i][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r10_val;
        end
    end

    always_ff @(posedge i_clk) begin
        o_out_px     <= n11_out[0];
        o_out_py     <= n11_out[1];
        o_out_pz     <= n11_out[2];
        o_out_energy <= n11_out[3];
        o_status     <= n11_status;
    end

`ifndef SYNTHESIS
    // every result comes from a beat accepted a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without matching input beat");

    // frame at rest only when the frame momentum was zero
    a_rest_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_REST) |->
        $past(i_frame_px == '0 && i_frame_py == '0 && i_frame_pz == '0, LATENCY))
        else $error("rest status for moving frame");

    // passthrough returns the original x momentum and energy
    a_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_REST || o_status == ST_BAD_MASS)) |->
        (o_out_px == $past(i_vec_px, LATENCY) && o_out_energy == $past(i_vec_energy, LATENCY)))
        else $error("passthrough vector altered");

    // overflow status means some output sits on a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SAT) |->
        (o_out_px[W-2:0] == {(W-1){~o_out_px[W-1]}}
         || o_out_py[W-2:0] == {(W-1){~o_out_py[W-1]}}
         || o_out_pz[W-2:0] == {(W-1){~o_out_pz[W-1]}}
         || o_out_energy[W-2:0] == {(W-1){~o_out_energy[W-1]}}))
        else $error("overflow status without saturated output");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench for the four-vector lorentz boost pipeline
`timescale 1ns / 1ps

module tb;
    import lbfv_pkg::*;

    localparam int W = 32;
    localparam int N_RANDOM = 1600;
    localparam int LATENCY = 6 * W + 13;
    localparam int STALL_LIMIT = 4000;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic OP_BOOST = 1'b0;

    // one input beat and one result beat
    typedef struct {
        logic                op;
        logic signed [W-1:0] vec [4];
        logic signed [W-1:0] frm [4];
    } t_beat;

    typedef struct {
        logic signed [W-1:0] mom [4];
        t_status             st;
    } t_boosted;

    typedef struct {
        t_beat    b;
        logic     known;
        t_boosted want;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_operation;
    logic [W-1:0]         i_vec_px, i_vec_py, i_vec_pz, i_vec_energy;
    logic [W-1:0]         i_frame_px, i_frame_py, i_frame_pz, i_frame_energy;
    logic                 o_valid;
    logic [W-1:0]         o_out_px, o_out_py, o_out_pz, o_out_energy;
    t_status              o_status;

    t_boosted pending_results [$];
    t_row     stim_rows [$];
    int       fails;
    int       quiet_cycles;

    lorentz_boost_four_vector #(.WORD_WIDTH(W)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation),
        .i_vec_px(i_vec_px), .i_vec_py(i_vec_py), .i_vec_pz(i_vec_pz),
        .i_vec_energy(i_vec_energy),
        .i_frame_px(i_frame_px), .i_frame_py(i_frame_py), .i_frame_pz(i_frame_pz),
        .i_frame_energy(i_frame_energy),
        .o_valid(o_valid), .o_out_px(o_out_px), .o_out_py(o_out_py),
        .o_out_pz(o_out_pz), .o_out_energy(o_out_energy), .o_status(o_status)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // floor square root of a nonnegative 64-bit value
    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int k = 31; k >= 0; k--) begin
            c = r | (64'd1 << k);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    // clamp to the word range, flag on clamp
    function automatic logic signed [W-1:0] clamp_word(logic signed [127:0] x,
                                                       inout logic ovf);
        if (x > 128'(WMAX)) begin
            ovf = 1'b1;
            return WMAX;
        end
        if (x < 128'(WMIN)) begin
            ovf = 1'b1;
            return WMIN;
        end
        return x[W-1:0];
    endfunction

    // exact boost of one beat on wide integers
    function automatic t_boosted boost_predict(t_beat b);
        t_boosted r;
        logic signed [127:0] p [4];
        logic signed [127:0] q [4];
        logic signed [127:0] q2, e2, m, dot, pf4, num, den, t;
        logic ovf;
        for (int i = 0; i < 4; i++) begin
            p[i] = b.vec[i];
            q[i] = b.frm[i];
            r.mom[i] = b.vec[i];
        end
        if (q[0] == 0 && q[1] == 0 && q[2] == 0) begin
            r.st = ST_REST;
            return r;
        end
        q2 = q[0] * q[0] + q[1] * q[1] + q[2] * q[2];
        e2 = q[3] * q[3];
        if (e2 <= q2) begin
            r.st = ST_BAD_MASS;
            return r;
        end
        m = $signed({64'd0, floor_sqrt(64'(e2 - q2))});
        dot = p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
        if (b.op == OP_INVERSE) dot = -dot;
        dot = dot + p[3] * q[3];
        pf4 = dot / m;
        num = pf4 + p[3];
        den = q[3] + m;
        ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            t = (num * q[i]) / den;
            if (b.op == OP_INVERSE) t = -t;
            r.mom[i] = clamp_word(p[i] + t, ovf);
        end
        r.mom[3] = clamp_word(pf4, ovf);
        r.st = ovf ? ST_SAT : ST_DONE;
        return r;
    endfunction

    function automatic t_beat make_beat(logic op,
            logic signed [W-1:0] px, logic signed [W-1:0] py,
            logic signed [W-1:0] pz, logic signed [W-1:0] pe,
            logic signed [W-1:0] qx, logic signed [W-1:0] qy,
            logic signed [W-1:0] qz, logic signed [W-1:0] qe);
        t_beat b;
        b.op = op;
        b.vec = '{px, py, pz, pe};
        b.frm = '{qx, qy, qz, qe};
        return b;
    endfunction

    // passthrough rows carry their expectation directly
    function automatic void add_row(t_beat b, logic known, t_status st);
        t_row r;
        r.b = b;
        r.known = known;
        r.want.mom = b.vec;
        r.want.st = st;
        stim_rows.push_back(r);
    endfunction

    // random beat, mostly physical frames
    function automatic t_beat random_beat();
        t_beat b;
        int mode;
        logic signed [W-1:0] sum;
        mode = $urandom_range(0, 99);
        b.op = $urandom_range(0, 1);
        for (int i = 0; i < 4; i++)
            b.vec[i] = $signed(W'($urandom)) >>> $urandom_range(0, 31);
        if (mode < 70) begin
            sum = '0;
            for (int i = 0; i < 3; i++) begin
                b.frm[i] = $signed(W'($urandom)) >>> $urandom_range(3, 31);
                sum = sum + (b.frm[i] < 0 ? -b.frm[i] : b.frm[i]);
            end
            b.frm[3] = sum + W'($urandom_range(1, 1 << $urandom_range(1, 29)));
            if ($urandom_range(0, 4) == 0) b.frm[3] = -b.frm[3];
        end else if (mode < 78) begin
            b.frm = '{0, 0, 0, W'($urandom)};
        end else if (mode < 86) begin
            for (int i = 0; i < 3; i++)
                b.frm[i] = $signed(W'($urandom)) >>> $urandom_range(1, 20);
            b.frm[3] = $signed(W'($urandom)) >>> 24;
        end else begin
            for (int i = 0; i < 4; i++) b.frm[i] = W'($urandom);
        end
        return b;
    endfunction

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat px=%h status=%0d",
                         $time, o_out_px, o_status);
                fails++;
            end else begin
                t_boosted w;
                logic [W-1:0] got [4];
                w = pending_results.pop_front();
                got = '{o_out_px, o_out_py, o_out_pz, o_out_energy};
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== w.mom[i]) begin
                        $display("%0t: component %0d expected %h actual %h",
                                 $time, i, w.mom[i], got[i]);
                        fails++;
                    end
                end
                if (o_status !== w.st) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, w.st, o_status);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // drive one beat and hold it until taken
    task automatic send_beat(t_beat b, logic known, t_boosted want, logic may_idle);
        if (may_idle && $urandom_range(0, 99) < 12) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= b.op;
        i_vec_px <= b.vec[0];
        i_vec_py <= b.vec[1];
        i_vec_pz <= b.vec[2];
        i_vec_energy <= b.vec[3];
        i_frame_px <= b.frm[0];
        i_frame_py <= b.frm[1];
        i_frame_pz <= b.frm[2];
        i_frame_energy <= b.frm[3];
        do @(posedge i_clk); while (busy);
        pending_results.push_back(known ? want : boost_predict(b));
    endtask

    initial begin
        t_boosted none;
        t_beat b;
        int waited;
        fails = 0;
        quiet_cycles = 0;
        none = '{mom: '{0, 0, 0, 0}, st: ST_DONE};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = 1'b0;
        {i_vec_px, i_vec_py, i_vec_pz, i_vec_energy} = '0;
        {i_frame_px, i_frame_py, i_frame_pz, i_frame_energy} = '0;

        // directed rows: passthrough cases typed in, the rest predicted
        add_row(make_beat(OP_BOOST, WMAX, WMIN, WMAX, WMIN, 0, 0, 0, 5 << 16),
                1'b1, ST_REST);
        add_row(make_beat(OP_INVERSE, WMIN, WMAX, 0, -1, 0, 0, 0, WMIN), 1'b1, ST_REST);
        add_row(make_beat(OP_BOOST, 1 << 16, 2, 3, 4, 1 << 16, 0, 0, 0), 1'b1,
                ST_BAD_MASS);
        add_row(make_beat(OP_INVERSE, 7, 8, 9, 10, 0, 3, 4, 5), 1'b1, ST_BAD_MASS);
        add_row(make_beat(OP_BOOST, -1, -1, -1, -1, WMIN, WMIN, WMIN, WMIN), 1'b1,
                ST_BAD_MASS);
        add_row(make_beat(OP_BOOST, 1 << 16, 2 << 16, 3 << 16, 5 << 16,
                          1 << 16, 0, 0, 2 << 16), 1'b0, ST_DONE);
        add_row(make_beat(OP_INVERSE, 1 << 16, 2 << 16, 3 << 16, 5 << 16,
                          1 << 16, 0, 0, 2 << 16), 1'b0, ST_DONE);
        add_row(make_beat(OP_BOOST, -4 << 16, 1 << 16, 0, 6 << 16,
                          0, 0, 3 << 16, -5 << 16), 1'b0, ST_DONE);
        add_row(make_beat(OP_BOOST, WMAX, WMAX, WMAX, WMAX,
                          0, 0, 32'h7000_0000, WMAX), 1'b0, ST_DONE);
        add_row(make_beat(OP_INVERSE, WMIN, WMIN, WMIN, WMIN,
                          0, 0, 32'h7000_0000, WMAX), 1'b0, ST_DONE);
        add_row(make_beat(OP_BOOST, 3, -3, 3, 9, 1, 0, 0, WMAX), 1'b0, ST_DONE);
        add_row(make_beat(OP_INVERSE, 100, 200, 300, 400, WMAX, 0, 0, WMIN), 1'b0,
                ST_DONE);
        add_row(make_beat(OP_BOOST, 0, 0, 0, 0, 1 << 10, -1 << 12, 1 << 14, 1 << 20),
                1'b0, ST_DONE);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[k])
            send_beat(stim_rows[k].b, stim_rows[k].known, stim_rows[k].want, 1'b1);

        for (int n = 0; n < N_RANDOM; n++) begin
            // hold off until the pipe drains once
            if (n == 800) begin
                start <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            b = random_beat();
            send_beat(b, 1'b0, none, !(n >= 300 && n < 700));
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        waited = 0;
        while (waited < LATENCY + 10) begin
            @(posedge i_clk);
            waited++;
        end
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/lbfv_pkg.sv
src/lbfv_sqrt.sv
src/lbfv_div.sv
src/lorentz_boost_four_vector.sv
tb/tb.sv
